// File: rtl/core/matrix_change_event_scanner_defines.svh
// ----------------------------------------------------------------------------
// matrix_change_event_scanner_defines
// assertion helpers shared by the scanner modules
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHANGE_EVENT_SCANNER_DEFINES_SVH
`define MATRIX_CHANGE_EVENT_SCANNER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCES_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("scanner check failed");

// next-cycle implication, checked outside reset
`define MCES_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("scanner check failed");

`endif

// File: rtl/core/mces_pkg.sv
// ----------------------------------------------------------------------------
// mces_pkg
// shared constants and types of the matrix change event scanner
// ----------------------------------------------------------------------------
`default_nettype none

package mces_pkg;

  // matrix geometry
  localparam int ROWS   = 8;
  localparam int COLS   = 8;
  localparam int STRIDE = 8;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // field widths
  localparam int OCC_W  = 64;
  localparam int BASE_W = 6;
  localparam int FILE_W = 3;
  localparam int RANK_W = 4;
  localparam int SEQ_W  = 32;

  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(8);
  localparam logic [SEQ_W-1:0]  SEQ_INIT = SEQ_W'(1);

  // one change event
  typedef struct packed {
    logic [FILE_W-1:0] file_index;
    logic [RANK_W-1:0] rank;
    logic              present;
    logic [SEQ_W-1:0]  seq;
  } event_t;

  // sequencer to event buffer
  typedef struct packed {
    logic push;
    logic flush;
  } buf_ctrl_t;

  // event buffer to sequencer
  typedef struct packed {
    logic push_ready;
    logic empty;
  } buf_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BASE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/matrix_change_event_scanner.sv
// a normal scan reads each row, loads it and compares it column by column, and ends with
//   a flush that moves the last event beat out; a full holding slot that waits on
//   out_stall holds the compare; a new scan is taken only once the last one has ended
//   and the block is idle again; a baseline scan writes each row to the board memory
// an event beat leaves one change later, or at scan end for the last one
// reset: row valid bits cleared (board reads all zeros), event counter to 1
// ----------------------------------------------------------------------------
// matrix_change_event_scanner
// 8x8 presence matrix change detector emitting, on a normal scan, one beat per changed square
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_change_event_scanner (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mces_pkg::OCC_W-1:0]  occupancy,
  input  logic                        baseline,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mces_pkg::FILE_W-1:0] file_index,
  output logic [mces_pkg::RANK_W-1:0] rank,
  output logic                        present,
  output logic [mces_pkg::SEQ_W-1:0]  sequence_res,
  output logic                        last
);

  import mces_pkg::*;

  event_t    ev;
  event_t    out_ev;
  buf_ctrl_t bctl;
  buf_stat_t bstat;

  // row sequencer with board memory
  mces_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .occupancy (occupancy),
    .baseline  (baseline),
    .ev        (ev),
    .bctl      (bctl),
    .bstat     (bstat)
  );

  // event holding slot and output register
  mces_evbuf u_evbuf (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .bctl      (bctl),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev),
    .out_last  (last)
  );

  assign file_index   = out_ev.file_index;
  assign rank         = out_ev.rank;
  assign present      = out_ev.present;
  assign sequence_res = out_ev.seq;

endmodule

`default_nettype wire

// File: rtl/core/mces_ram.sv
// ----------------------------------------------------------------------------
// mces_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mces_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mces_ctrl.sv
// ----------------------------------------------------------------------------
// mces_ctrl
// row sequencer: baseline scans only write rows; normal ones read each stored row, walk its squares, write it back
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_change_event_scanner_defines.svh"

module mces_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mces_pkg::OCC_W-1:0] occupancy,
  input  logic                       baseline,
  output mces_pkg::event_t           ev,
  output mces_pkg::buf_ctrl_t        bctl,
  input  mces_pkg::buf_stat_t        bstat
);

  import mces_pkg::*;

  state_t            state;
  logic [OCC_W-1:0]  occ_q;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [COLS-1:0]   row_bits;
  logic [ROWS-1:0]   row_vld;
  logic [SEQ_W-1:0]  counter;

  logic [BASE_W-1:0] row_base;
  logic [COLS-1:0]   occ_row;
  logic              diff;
  logic              advance;
  logic              in_acc;
  logic              ram_we;
  logic              ram_re;
  logic [COLS-1:0]   ram_rdata;

  // scanned bits of the current row
  assign row_base = BASE_W'(row) * BASE_W'(STRIDE);
  assign occ_row  = occ_q[row_base +: COLS];

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // square compare and walker advance
  assign diff    = (state == ST_SCAN) && (occ_row[col] != row_bits[col]);
  assign advance = (state == ST_SCAN) && (!diff || bstat.push_ready);

  assign bctl.push  = diff;
  assign bctl.flush = (state == ST_FLUSH);

  assign ev.file_index = FILE_W'(col);
  assign ev.rank       = RANK_TOP - RANK_W'(row);
  assign ev.present    = occ_row[col];
  assign ev.seq        = counter;

  // the stored row after a scan equals the scanned row
  assign ram_we = (state == ST_BASE) || (advance && (col == COL_LAST));
  assign ram_re = (state == ST_READ);

  mces_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (occ_row),
    .re    (ram_re),
    .raddr (row),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row     <= '0;
      col     <= '0;
      row_vld <= '0;
      counter <= SEQ_INIT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            row   <= '0;
            col   <= '0;
            state <= baseline ? ST_BASE : ST_READ;
          end
        end
        ST_BASE: begin
          row_vld[row] <= 1'b1;
          if (row == ROW_LAST) begin
            state <= ST_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          col   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (advance) begin
            if (diff) begin
              counter <= counter + 1'b1;
            end
            if (col == COL_LAST) begin
              row_vld[row] <= 1'b1;
              if (row == ROW_LAST) begin
                state <= ST_FLUSH;
              end else begin
                row   <= row + 1'b1;
                state <= ST_READ;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (bstat.empty) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // capture the scan and the stored row; a row never written reads as zero
  always_ff @(posedge clk) begin
    if (in_acc) begin
      occ_q <= occupancy;
    end
    if (state == ST_LOAD) begin
      row_bits <= row_vld[row] ? ram_rdata : '0;
    end
  end

  `MCES_ASSERT_NEXT(a_cnt_hold, clk, rst, !(diff && bstat.push_ready), $stable(counter))
  `MCES_ASSERT_NEXT(a_flush_done, clk, rst, (state == ST_FLUSH) && bstat.empty,
                    state == ST_IDLE)
  `MCES_ASSERT_NEXT(a_start, clk, rst, in_acc, (state == ST_BASE) || (state == ST_READ))

endmodule

`default_nettype wire

// File: rtl/core/mces_evbuf.sv
// ----------------------------------------------------------------------------
// mces_evbuf
// one-event holding slot and output register; marks the final event of a scan
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_change_event_scanner_defines.svh"

module mces_evbuf (
  input  logic                clk,
  input  logic                rst,
  input  mces_pkg::event_t    ev,
  input  mces_pkg::buf_ctrl_t bctl,
  output mces_pkg::buf_stat_t bstat,
  output logic                out_valid,
  input  logic                out_stall,
  output mces_pkg::event_t    out_ev,
  output logic                out_last
);

  import mces_pkg::*;

  event_t hold;
  logic   hold_v;
  logic   out_free;
  logic   push_acc;
  logic   flush_mv;

  // a held event moves out once a later one shows up or the scan ends
  assign out_free = !out_valid || !out_stall;
  assign bstat.push_ready = !hold_v || out_free;
  assign bstat.empty      = !hold_v;
  assign push_acc = bctl.push && bstat.push_ready;
  assign flush_mv = !bctl.push && bctl.flush && hold_v && out_free;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (push_acc) begin
        hold_v <= 1'b1;
        if (hold_v) begin
          out_valid <= 1'b1;
        end else if (out_free) begin
          out_valid <= 1'b0;
        end
      end else if (flush_mv) begin
        hold_v    <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push_acc) begin
      hold <= ev;
      if (hold_v) begin
        out_ev   <= hold;
        out_last <= 1'b0;
      end
    end else if (flush_mv) begin
      out_ev   <= hold;
      out_last <= 1'b1;
    end
  end

  `MCES_ASSERT_NEXT(a_push_out, clk, rst, push_acc && hold_v, out_valid && !out_last)
  `MCES_ASSERT_NEXT(a_flush_out, clk, rst, flush_mv, out_valid && out_last && !hold_v)

endmodule

`default_nettype wire
